>>> hw/rtl/lsp_pkg.sv
// Shared types and constants for the looping sample player.
package lsp_pkg;

   // Default sizes of the sample store
   localparam int unsigned MAX_FRAMES_DEF   = 65536;
   localparam int unsigned NUM_CHANNELS_DEF = 2;

   // Field widths
   localparam int unsigned REQ_TYPE_W = 2;
   localparam int unsigned INDEX_W    = 16;
   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned MIX_W      = 24;
   localparam int unsigned PHASE_W    = 32;
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned SPEED_W    = 21;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned SLEN_W     = 17;
   localparam int unsigned ALEN_W     = 21;
   localparam int unsigned CHANS_W    = 2;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 21;
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned RSP_USER_W = 2;

   // Request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_START = 2'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP  = 2'd3;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SPEED = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAIN  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOOP  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLEN  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ALEN  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHANS = 3'd5;

   // Speed clamp, Q5.16
   localparam logic [SPEED_W-1:0] SPEED_MIN = 21'd3277;
   localparam logic [SPEED_W-1:0] SPEED_MAX = 21'd1310720;

   // Output saturation limits
   localparam logic signed [MIX_W-1:0] OUT_MAX = 24'sh7FFFFF;
   localparam logic signed [MIX_W-1:0] OUT_MIN = 24'sh800000;

   // Dividend width of the phase reduction unit
   localparam int unsigned DVD_W = PHASE_W + 1;

   // Controller to datapath commands
   typedef struct packed {
      logic wr;          // store a sample beat
      logic cap;         // capture the mix of a tick
      logic mod_phase;   // reduce the stored phase
      logic mod_next;    // reduce phase plus speed
      logic take_phase;  // keep reduced next phase
      logic rd_en;
      logic rd_i1;       // read the following frame
      logic rd_right;    // read the right voice
      logic lat_s0;
      logic lat_s1;
      logic mul_diff;
      logic mul_gain;
      logic fin;         // finish one voice
      logic adv;         // advance position
      logic pass;        // stopped tick: mix through
      logic push;        // load result register
   } cmd_type;

   // Datapath status
   typedef struct packed {
      logic mod_busy;
      logic pass_end;
      logic loop_en;
      logic rsp_free;
   } sts_type;

endpackage

>>> hw/rtl/lsp_ctrl.sv
// Controller state machine of the looping sample player.
module lsp_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lsp_pkg::REQ_TYPE_W-1:0]   req_type,
   output lsp_pkg::cmd_type                 cmd,
   input  lsp_pkg::sts_type                 sts
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MOD1 = 4'd1;
   localparam logic [3:0] S_RD0  = 4'd2;
   localparam logic [3:0] S_RD1  = 4'd3;
   localparam logic [3:0] S_RD2  = 4'd4;
   localparam logic [3:0] S_MUL1 = 4'd5;
   localparam logic [3:0] S_MUL2 = 4'd6;
   localparam logic [3:0] S_FIN  = 4'd7;
   localparam logic [3:0] S_ADV  = 4'd8;
   localparam logic [3:0] S_MOD2 = 4'd9;
   localparam logic [3:0] S_PASS = 4'd10;
   localparam logic [3:0] S_PUSH = 4'd11;

   localparam logic [1:0] TR_STOPPED  = 2'd0;
   localparam logic [1:0] TR_STARTING = 2'd1;
   localparam logic [1:0] TR_PLAYING  = 2'd2;
   localparam logic [1:0] TR_STOPPING = 2'd3;

   logic [3:0] state_ff, state_in;
   logic [1:0] tr_ff, tr_in;
   logic       right_ff, right_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state, transport and commands
   always_comb begin
      state_in = state_ff;
      tr_in    = tr_ff;
      right_in = right_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  lsp_pkg::REQ_WRITE: cmd.wr = 1'b1;
                  lsp_pkg::REQ_START: tr_in = TR_STARTING;
                  lsp_pkg::REQ_STOP: begin
                     if (tr_ff != TR_STOPPED) tr_in = TR_STOPPING;
                  end
                  default: begin
                     cmd.cap = 1'b1;
                     if (tr_ff == TR_STOPPED) begin
                        state_in = S_PASS;
                     end else begin
                        tr_in         = (tr_ff == TR_STOPPING) ? TR_STOPPED : TR_PLAYING;
                        cmd.mod_phase = 1'b1;
                        right_in      = 1'b0;
                        state_in      = S_MOD1;
                     end
                  end
               endcase
            end
         end
         S_MOD1: begin
            if (!sts.mod_busy) state_in = S_RD0;
         end
         S_RD0: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_right = right_ff;
            state_in     = S_RD1;
         end
         S_RD1: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_i1    = 1'b1;
            cmd.rd_right = right_ff;
            cmd.lat_s0   = 1'b1;
            state_in     = S_RD2;
         end
         S_RD2: begin
            cmd.lat_s1 = 1'b1;
            state_in   = S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_diff = 1'b1;
            state_in     = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_gain = 1'b1;
            state_in     = S_FIN;
         end
         S_FIN: begin
            cmd.fin      = 1'b1;
            cmd.rd_right = right_ff;
            right_in     = 1'b1;
            state_in     = right_ff ? S_ADV : S_RD0;
         end
         S_ADV: begin
            cmd.adv = 1'b1;
            if (sts.pass_end) begin
               if (!sts.loop_en) tr_in = TR_STOPPED;
               state_in = S_PUSH;
            end else begin
               cmd.mod_next = 1'b1;
               state_in     = S_MOD2;
            end
         end
         S_MOD2: begin
            if (!sts.mod_busy) begin
               cmd.take_phase = 1'b1;
               state_in       = S_PUSH;
            end
         end
         S_PASS: begin
            cmd.pass = 1'b1;
            state_in = S_PUSH;
         end
         S_PUSH: begin
            if (sts.rsp_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tr_ff    <= TR_STOPPED;
         right_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tr_ff    <= tr_in;
         right_ff <= right_in;
      end
   end

   // Checks
   a_mod_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.mod_phase || cmd.mod_next) |-> !sts.mod_busy)
      else $error("phase reduction started while busy");
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> sts.rsp_free)
      else $error("result loaded over an untaken beat");
   a_end_stop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADV && sts.pass_end && !sts.loop_en) |=> tr_ff == TR_STOPPED)
      else $error("transport still running after last pass");
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == lsp_pkg::REQ_WRITE) |=> state_ff == S_IDLE)
      else $error("sample write left the idle state");

endmodule

>>> hw/rtl/lsp_dpath.sv
// Datapath of the looping sample player: store, phase unit, interpolator.
module lsp_dpath #(
   parameter int unsigned MAX_FRAMES   = lsp_pkg::MAX_FRAMES_DEF,
   parameter int unsigned NUM_CHANNELS = lsp_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lsp_pkg::cmd_type                      cmd,
   output lsp_pkg::sts_type                      sts,
   input  logic [lsp_pkg::INDEX_W-1:0]           write_index,
   input  logic                                  write_channel,
   input  logic signed [lsp_pkg::SAMPLE_W-1:0]   write_value,
   input  logic signed [lsp_pkg::MIX_W-1:0]      mix_in_left,
   input  logic signed [lsp_pkg::MIX_W-1:0]      mix_in_right,
   input  logic                                  csr_we,
   input  logic [lsp_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [lsp_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic [lsp_pkg::RSP_USER_W-1:0]        rsp_tuser
);

   localparam int unsigned FW    = $clog2(MAX_FRAMES);
   localparam int unsigned LW    = $clog2(MAX_FRAMES + 1);
   localparam int unsigned LQW   = LW + lsp_pkg::FRAC_W;
   localparam int unsigned RW    = LQW + 1;
   localparam int unsigned AW    = $clog2(NUM_CHANNELS * MAX_FRAMES);
   localparam int unsigned DEPTH = NUM_CHANNELS * MAX_FRAMES;
   localparam int unsigned DVD_W = lsp_pkg::DVD_W;
   localparam int unsigned CNT_W = $clog2(DVD_W + 1);
   localparam int unsigned PW    = 51;

   // Configuration registers
   logic [lsp_pkg::SPEED_W-1:0] speed_ff;
   logic [lsp_pkg::GAIN_W-1:0]  gain_ff;
   logic                        loop_ff;
   logic [lsp_pkg::SLEN_W-1:0]  slen_ff;
   logic [lsp_pkg::ALEN_W-1:0]  alen_ff;
   logic [lsp_pkg::CHANS_W-1:0] chans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= 21'd65536;
         gain_ff  <= 16'd16384;
         loop_ff  <= 1'b0;
         slen_ff  <= 17'd1;
         alen_ff  <= 21'd1;
         chans_ff <= 2'd1;
      end else if (csr_we) begin
         unique case (csr_addr)
            lsp_pkg::CSR_SPEED: speed_ff <= csr_wdata;
            lsp_pkg::CSR_GAIN:  gain_ff  <= csr_wdata[lsp_pkg::GAIN_W-1:0];
            lsp_pkg::CSR_LOOP:  loop_ff  <= csr_wdata[0];
            lsp_pkg::CSR_SLEN:  slen_ff  <= csr_wdata[lsp_pkg::SLEN_W-1:0];
            lsp_pkg::CSR_ALEN:  alen_ff  <= csr_wdata;
            lsp_pkg::CSR_CHANS: chans_ff <= csr_wdata[lsp_pkg::CHANS_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped register values
   logic [lsp_pkg::SPEED_W-1:0] speed_c;
   logic [31:0]                 len32;
   logic [LW-1:0]               len_c;
   logic [lsp_pkg::ALEN_W-1:0]  alen_c;
   logic                        right_src;
   logic [RW-1:0]               lenq;

   always_comb begin
      priority if (speed_ff < lsp_pkg::SPEED_MIN) speed_c = lsp_pkg::SPEED_MIN;
      else if (speed_ff > lsp_pkg::SPEED_MAX) speed_c = lsp_pkg::SPEED_MAX;
      else speed_c = speed_ff;
      priority if (slen_ff == '0) len32 = 32'd1;
      else if (32'(slen_ff) > MAX_FRAMES) len32 = 32'(MAX_FRAMES);
      else len32 = 32'(slen_ff);
   end
   assign len_c     = len32[LW-1:0];
   assign alen_c    = (alen_ff == '0) ? lsp_pkg::ALEN_W'(1) : alen_ff;
   assign right_src = (NUM_CHANNELS > 1) && (chans_ff >= 2'd2);
   assign lenq      = RW'({len_c, lsp_pkg::FRAC_W'(0)});

   // Phase reduction: restoring remainder, one dividend bit per cycle
   logic [RW-1:0]    rem_ff;
   logic [DVD_W-1:0] dvd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic [RW-1:0]    trial;
   logic [DVD_W-1:0] next_dvd;
   logic [lsp_pkg::PHASE_W-1:0] phase_ff;

   assign trial    = {rem_ff[RW-2:0], dvd_ff[DVD_W-1]};
   assign next_dvd = DVD_W'(rem_ff[lsp_pkg::PHASE_W-1:0]) + DVD_W'(speed_c);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (cmd.mod_phase || cmd.mod_next) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DVD_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mod_phase || cmd.mod_next) begin
         rem_ff <= '0;
         dvd_ff <= cmd.mod_phase ? DVD_W'(phase_ff) : next_dvd;
      end else if (busy_ff) begin
         rem_ff <= (trial >= lenq) ? trial - lenq : trial;
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
      end
   end

   // Frame indexes from the reduced phase
   logic [FW-1:0]               i0;
   logic [FW:0]                 i0p1;
   logic [FW-1:0]               i1;
   logic [lsp_pkg::FRAC_W-1:0]  frac;

   assign i0   = rem_ff[lsp_pkg::FRAC_W +: FW];
   assign frac = rem_ff[lsp_pkg::FRAC_W-1:0];
   assign i0p1 = {1'b0, i0} + 1'b1;
   assign i1   = (i0p1 == (FW+1)'(len_c)) ? '0 : i0p1[FW-1:0];

   // Position and phase state
   logic [lsp_pkg::ALEN_W-1:0] pos_ff;
   logic [lsp_pkg::ALEN_W:0]   pos_next;

   assign pos_next = {1'b0, pos_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         phase_ff <= '0;
      end else if (cmd.adv && sts.pass_end) begin
         pos_ff   <= '0;
         phase_ff <= '0;
      end else begin
         if (cmd.adv) pos_ff <= pos_next[lsp_pkg::ALEN_W-1:0];
         if (cmd.take_phase) phase_ff <= rem_ff[lsp_pkg::PHASE_W-1:0];
      end
   end

   // Sample store
   logic signed [lsp_pkg::SAMPLE_W-1:0] mem [DEPTH];
   logic signed [lsp_pkg::SAMPLE_W-1:0] rdata_ff;
   logic [AW-1:0] waddr, raddr;
   logic          wr_ok;
   logic [FW-1:0] ridx;
   logic          rch;

   assign wr_ok = (32'(write_index) < MAX_FRAMES) && (32'(write_channel) < NUM_CHANNELS);
   assign waddr = AW'(32'(write_channel) * MAX_FRAMES + 32'(write_index));
   assign ridx  = cmd.rd_i1 ? i1 : i0;
   assign rch   = cmd.rd_right && right_src;
   assign raddr = AW'(32'(rch) * MAX_FRAMES + 32'(ridx));

   always_ff @(posedge clock) begin
      if (cmd.wr && wr_ok) mem[waddr] <= write_value;
      if (cmd.rd_en) rdata_ff <= mem[raddr];
   end

   // Interpolate, scale, add and saturate
   logic signed [lsp_pkg::SAMPLE_W-1:0] s0_ff, s1_ff;
   logic signed [lsp_pkg::SAMPLE_W:0]   diff;
   logic signed [33:0]                  d_ff;
   logic signed [34:0]                  v;
   logic signed [PW-1:0]                prod_ff;
   logic signed [PW-1:0]                rounded;
   logic signed [PW-23:0]               scaled;
   logic signed [PW-22:0]               sum;
   logic signed [lsp_pkg::MIX_W-1:0]    mix_l_ff, mix_r_ff, mix_sel, sat;

   assign diff    = 17'(s1_ff) - 17'(s0_ff);
   assign v       = (35'(s0_ff) <<< lsp_pkg::FRAC_W) + 35'(d_ff);
   assign rounded = prod_ff + PW'(signed'(2 ** 21));
   assign scaled  = rounded[PW-1:22];
   assign mix_sel = cmd.rd_right ? mix_r_ff : mix_l_ff;
   assign sum     = (PW-21)'(scaled) + (PW-21)'(mix_sel);

   always_comb begin
      priority if (sum > (PW-21)'(lsp_pkg::OUT_MAX)) sat = lsp_pkg::OUT_MAX;
      else if (sum < (PW-21)'(lsp_pkg::OUT_MIN)) sat = lsp_pkg::OUT_MIN;
      else sat = sum[lsp_pkg::MIX_W-1:0];
   end

   logic signed [lsp_pkg::MIX_W-1:0] res_l_ff, res_r_ff;
   logic                             played_ff, ended_ff;

   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         mix_l_ff <= mix_in_left;
         mix_r_ff <= mix_in_right;
      end
      if (cmd.lat_s0) s0_ff <= rdata_ff;
      if (cmd.lat_s1) s1_ff <= rdata_ff;
      if (cmd.mul_diff) d_ff <= 34'(diff * $signed({1'b0, frac}));
      if (cmd.mul_gain) prod_ff <= PW'(v * $signed({1'b0, gain_ff}));
      if (cmd.fin) begin
         if (cmd.rd_right) res_r_ff <= sat;
         else res_l_ff <= sat;
         played_ff <= 1'b1;
      end
      if (cmd.adv) ended_ff <= sts.pass_end;
      if (cmd.pass) begin
         res_l_ff  <= mix_l_ff;
         res_r_ff  <= mix_r_ff;
         played_ff <= 1'b0;
         ended_ff  <= 1'b0;
      end
   end

   // Result register
   logic                            rsp_valid_ff;
   logic [lsp_pkg::RSP_DATA_W-1:0]  rsp_data_ff;
   logic [lsp_pkg::RSP_USER_W-1:0]  rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= {res_r_ff, res_l_ff};
         rsp_user_ff <= {ended_ff, played_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign sts.mod_busy = busy_ff;
   assign sts.pass_end = (pos_next >= {1'b0, alen_c});
   assign sts.loop_en  = loop_ff;
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

endmodule

>>> hw/rtl/looping_sample_player_resampler.sv
// Top level of the looping sample player with linear-interpolation resampling.
//
// Requests arrive as beats on req_*: tuser carries the kind (tick, sample
// write, start, stop), tdata the write fields and the 24-bit stereo mix.
// A tick gives exactly one result beat on rsp_*; other kinds give none.
// The user is to write registers through csr_we/csr_addr/csr_wdata only while
// idle; the block does not enforce it. Sample writes, start and stop stay in
// the idle state, which remains ready for the next request. A tick while
// stopped returns the captured mix through the pass and push states.
// A playing tick reduces the phase modulo the sample length with a restoring
// remainder unit at one bit per cycle, once when the tick ends a pass and
// twice otherwise, and the two store reads and two multiplies per voice share
// one memory port and one multiplier chain.
// Reset clears transport to stopped, position and phase to zero and the
// registers to their defaults; the sample store is not cleared.
// A result waits in its output register while rsp_tready is low; the next
// request is taken once the previous tick is finished.
module looping_sample_player_resampler #(
   parameter int unsigned MAX_FRAMES   = lsp_pkg::MAX_FRAMES_DEF,
   parameter int unsigned NUM_CHANNELS = lsp_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // write_index, write_channel, write_value, mix_in_left, mix_in_right, zero pad
   input  logic [lsp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_type
   input  logic [lsp_pkg::REQ_TYPE_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_left, out_right
   output logic [lsp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // was_playing, pass_ended
   output logic [lsp_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                csr_we,
   input  logic [lsp_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [lsp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   lsp_pkg::cmd_type cmd;
   lsp_pkg::sts_type sts;

   lsp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

   lsp_dpath #(
      .MAX_FRAMES   (MAX_FRAMES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .write_index   (req_tdata[15:0]),
      .write_channel (req_tdata[16]),
      .write_value   (req_tdata[32:17]),
      .mix_in_left   (req_tdata[56:33]),
      .mix_in_right  (req_tdata[80:57]),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule
